// ===== rtl/harrs_pkg.sv =====
package harrs_pkg;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NO_ENDPOINTS = 2'd1,
      ST_ALL_DOWN     = 2'd2,
      ST_BAD_ENDPOINT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_NUM_ENDPOINTS = 2'd0,
      CSR_PATH_COUNTS   = 2'd1,
      CSR_FAIL_TIMEOUT  = 2'd2,
      CSR_HINT_ENABLE   = 2'd3
   } csr_index_type;

   localparam logic [31:0] FAIL_TIMEOUT_RESET = 32'd30;
   localparam int          NIBBLE_SLOTS       = 8;

   typedef struct packed {
      logic        action;
      logic [31:0] now;
      logic [2:0]  fail_endpoint;
      logic        fail_path_known;
      logic [2:0]  fail_path;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  chosen_endpoint;
      logic        hint_valid;
      logic [2:0]  chosen_path;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FAIL_WR,
      S_EP_STEP,
      S_PATH_CMP,
      S_HINT_CHECK,
      S_HINT_STEP,
      S_HINT_CMP,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic       load_req;
      logic       fail_mark;
      logic       fail_write;
      logic       set_status;
      status_type status;
      logic       ep_start;
      logic       ep_step;
      logic       path_next;
      logic       pick_chosen;
      logic       hint_probe;
      logic       hint_clear;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_fail;
      logic no_ep;
      logic fail_bad;
      logic fail_single;
      logic fail_empty;
      logic quick_ok;
      logic rd_expired;
      logic path_last;
      logic tries_done;
      logic hint_on;
      logic hint_hit;
      logic hint_done;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== rtl/harrs_ram.sv =====
module harrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/harrs_ctrl.sv =====
module harrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  harrs_pkg::sts_type  sts,
   output harrs_pkg::cmd_type  cmd
);

   harrs_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= harrs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == harrs_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         harrs_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = harrs_pkg::S_DISPATCH;
            end
         end
         harrs_pkg::S_DISPATCH: begin
            if (sts.is_fail) begin
               if (sts.fail_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = harrs_pkg::ST_BAD_ENDPOINT;
                  state_in       = harrs_pkg::S_FINISH;
               end else begin
                  cmd.fail_mark = 1'b1;
                  // endpoint without sub-paths: stamp only, nothing to write
                  if (!sts.fail_single && sts.fail_empty) begin
                     state_in = harrs_pkg::S_FINISH;
                  end else begin
                     state_in = harrs_pkg::S_FAIL_WR;
                  end
               end
            end else if (sts.no_ep) begin
               cmd.set_status = 1'b1;
               cmd.status     = harrs_pkg::ST_NO_ENDPOINTS;
               state_in       = harrs_pkg::S_FINISH;
            end else begin
               cmd.ep_start = 1'b1;
               state_in     = harrs_pkg::S_EP_STEP;
            end
         end
         harrs_pkg::S_FAIL_WR: begin
            cmd.fail_write = 1'b1;
            if (sts.fail_single || sts.path_last) begin
               state_in = harrs_pkg::S_FINISH;
            end
         end
         harrs_pkg::S_EP_STEP: begin
            cmd.ep_step = 1'b1;
            if (sts.quick_ok) begin
               state_in = harrs_pkg::S_HINT_CHECK;
            end else begin
               state_in = harrs_pkg::S_PATH_CMP;
            end
         end
         harrs_pkg::S_PATH_CMP: begin
            if (sts.rd_expired) begin
               state_in = harrs_pkg::S_HINT_CHECK;
            end else if (sts.path_last) begin
               if (sts.tries_done) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = harrs_pkg::ST_ALL_DOWN;
                  state_in       = harrs_pkg::S_FINISH;
               end else begin
                  state_in = harrs_pkg::S_EP_STEP;
               end
            end else begin
               cmd.path_next = 1'b1;
            end
         end
         harrs_pkg::S_HINT_CHECK: begin
            cmd.pick_chosen = 1'b1;
            if (sts.hint_on) begin
               state_in = harrs_pkg::S_HINT_STEP;
            end else begin
               state_in = harrs_pkg::S_FINISH;
            end
         end
         harrs_pkg::S_HINT_STEP: begin
            cmd.hint_probe = 1'b1;
            if (sts.hint_hit) begin
               state_in = harrs_pkg::S_FINISH;
            end else begin
               state_in = harrs_pkg::S_HINT_CMP;
            end
         end
         harrs_pkg::S_HINT_CMP: begin
            if (sts.rd_expired) begin
               cmd.hint_clear = 1'b1;
               state_in       = harrs_pkg::S_FINISH;
            end else if (sts.hint_done) begin
               state_in = harrs_pkg::S_FINISH;
            end else begin
               // probe the next sub-path while the last read is retired
               cmd.hint_probe = 1'b1;
               if (sts.hint_hit) begin
                  state_in = harrs_pkg::S_FINISH;
               end
            end
         end
         harrs_pkg::S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = harrs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = harrs_pkg::S_IDLE;
         end
      endcase
   end

   a_finish_leaves: assert property (@(posedge clock) disable iff (reset)
      state_ff == harrs_pkg::S_FINISH && !sts.rsp_busy |=> state_ff == harrs_pkg::S_IDLE)
      else $error("finish state did not retire with a free output register");

   a_probe_state: assert property (@(posedge clock) disable iff (reset)
      cmd.hint_probe |-> state_ff == harrs_pkg::S_HINT_STEP ||
                         state_ff == harrs_pkg::S_HINT_CMP)
      else $error("sub-path probe issued outside the hint phase");

endmodule

// ===== rtl/harrs_dpath.sv =====
module harrs_dpath #(
   parameter int MAX_ENDPOINTS = 8,
   parameter int MAX_PATHS     = 8,
   parameter int TIME_BITS     = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  harrs_pkg::req_type       req_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  harrs_pkg::csr_index_type csr_index,
   input  logic [31:0]              csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output harrs_pkg::rsp_type       rsp_data,
   input  harrs_pkg::cmd_type       cmd,
   output harrs_pkg::sts_type       sts
);

   localparam int EW    = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
   localparam int PW    = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
   localparam int NW    = $clog2(MAX_ENDPOINTS + 1);
   localparam int CW    = $clog2(MAX_PATHS + 1);
   localparam int AW    = EW + PW;
   localparam int DEPTH = 2 ** AW;
   localparam int CMPW  = (TIME_BITS > 32) ? TIME_BITS : 32;

   // sub-path count of one endpoint, saturated; endpoints past the nibbles have none
   function automatic logic [CW-1:0] paths_of(input logic [EW-1:0] e,
                                              input logic [31:0] pc);
      logic [3:0] nib;
      nib = '0;
      for (int k = 0; k < harrs_pkg::NIBBLE_SLOTS; k++) begin
         if (k < MAX_ENDPOINTS && 32'(e) == k) begin
            nib = pc[4*k +: 4];
         end
      end
      if (32'(nib) > MAX_PATHS) begin
         return CW'(MAX_PATHS);
      end
      return CW'(nib);
   endfunction

   function automatic logic [MAX_PATHS-1:0] path_mask(input logic [CW-1:0] c);
      logic [MAX_PATHS-1:0] m;
      for (int p = 0; p < MAX_PATHS; p++) begin
         m[p] = (32'(c) > p);
      end
      return m;
   endfunction

   // age wraps modulo the stamp width
   function automatic logic expired(input logic [TIME_BITS-1:0] stamp,
                                    input logic [TIME_BITS-1:0] now_t,
                                    input logic [31:0] tmo);
      logic [TIME_BITS-1:0] age;
      age = now_t - stamp;
      return CMPW'(age) >= CMPW'(tmo);
   endfunction

   logic [3:0]            num_ep_ff, num_ep_in;
   logic [31:0]           path_counts_ff, path_counts_in;
   logic [31:0]           fail_timeout_ff, fail_timeout_in;
   logic                  hint_en_ff, hint_en_in;

   harrs_pkg::req_type    req_ff, req_in;
   logic [EW-1:0]         ep_ptr_ff, ep_ptr_in;
   logic [EW-1:0]         cur_ep_ff, cur_ep_in;
   logic [PW-1:0]         path_ptr_ff [MAX_ENDPOINTS];
   logic [PW-1:0]         path_ptr_in [MAX_ENDPOINTS];
   logic [MAX_ENDPOINTS-1:0] ep_failed_ff, ep_failed_in;
   logic [TIME_BITS-1:0]  ep_time_ff [MAX_ENDPOINTS];
   logic [TIME_BITS-1:0]  ep_time_in [MAX_ENDPOINTS];
   logic [MAX_PATHS-1:0]  path_failed_ff [MAX_ENDPOINTS];
   logic [MAX_PATHS-1:0]  path_failed_in [MAX_ENDPOINTS];
   logic [PW-1:0]         idx_ff, idx_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         hcnt_ff, hcnt_in;
   harrs_pkg::rsp_type    res_ff, res_in;
   harrs_pkg::rsp_type    rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [TIME_BITS-1:0]  now_t;
   logic [NW-1:0]         n;
   logic [EW-1:0]         nx;
   logic [EW-1:0]         fe_e;
   logic [PW-1:0]         fp_p;
   logic [CW-1:0]         c_nx;
   logic [CW-1:0]         c_cur;
   logic [CW-1:0]         c_fe;
   logic [PW-1:0]         pp_cur;
   logic [PW-1:0]         hidx;
   logic [PW-1:0]         hnext;
   logic [PW-1:0]         idx_inc;
   logic                  hfail;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [AW-1:0]         ram_raddr;
   logic [TIME_BITS-1:0]  ram_rdata;

   harrs_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
   ) u_stamp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (now_t),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign now_t   = TIME_BITS'(req_ff.now);
   assign n       = (32'(num_ep_ff) > MAX_ENDPOINTS) ? NW'(MAX_ENDPOINTS) : NW'(num_ep_ff);
   assign nx      = (32'(ep_ptr_ff) + 32'd1 >= 32'(n)) ? '0 : EW'(32'(ep_ptr_ff) + 32'd1);
   assign fe_e    = EW'(req_ff.fail_endpoint);
   assign fp_p    = PW'(req_ff.fail_path);
   assign c_nx    = paths_of(nx, path_counts_ff);
   assign c_cur   = paths_of(cur_ep_ff, path_counts_ff);
   assign c_fe    = paths_of(fe_e, path_counts_ff);
   assign idx_inc = PW'(32'(idx_ff) + 32'd1);

   // hint rotation: stale pointer wraps to zero
   assign pp_cur = path_ptr_ff[cur_ep_ff];
   assign hidx   = (32'(pp_cur) >= 32'(c_cur)) ? '0 : pp_cur;
   assign hnext  = (32'(hidx) + 32'd1 >= 32'(c_cur)) ? '0 : PW'(32'(hidx) + 32'd1);
   assign hfail  = path_failed_ff[cur_ep_ff][hidx];

   assign ram_we    = cmd.fail_write;
   assign ram_waddr = {cur_ep_ff, idx_ff};

   always_comb begin
      if (cmd.ep_step) begin
         ram_raddr = {nx, PW'(0)};
      end else if (cmd.path_next) begin
         ram_raddr = {cur_ep_ff, idx_inc};
      end else if (cmd.hint_probe) begin
         ram_raddr = {cur_ep_ff, hidx};
      end else begin
         ram_raddr = {cur_ep_ff, idx_ff};
      end
   end

   always_comb begin
      sts.is_fail     = req_ff.action;
      sts.no_ep       = (n == '0);
      sts.fail_bad    = (32'(req_ff.fail_endpoint) >= 32'(n));
      sts.fail_single = req_ff.fail_path_known && (32'(req_ff.fail_path) < 32'(c_fe));
      sts.fail_empty  = (c_fe == '0);
      sts.quick_ok    = (c_nx == '0) || !ep_failed_ff[nx] ||
                        expired(ep_time_ff[nx], now_t, fail_timeout_ff) ||
                        (|(~path_failed_ff[nx] & path_mask(c_nx)));
      sts.rd_expired  = expired(ram_rdata, now_t, fail_timeout_ff);
      sts.path_last   = (32'(idx_ff) + 32'd1 >= 32'(c_cur));
      sts.tries_done  = (cnt_ff == n);
      sts.hint_on     = hint_en_ff && (c_cur != '0);
      sts.hint_hit    = !hfail;
      sts.hint_done   = (hcnt_ff == c_cur);
      sts.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      num_ep_in       = num_ep_ff;
      path_counts_in  = path_counts_ff;
      fail_timeout_in = fail_timeout_ff;
      hint_en_in      = hint_en_ff;
      req_in          = req_ff;
      ep_ptr_in       = ep_ptr_ff;
      cur_ep_in       = cur_ep_ff;
      path_ptr_in     = path_ptr_ff;
      ep_failed_in    = ep_failed_ff;
      ep_time_in      = ep_time_ff;
      path_failed_in  = path_failed_ff;
      idx_in          = idx_ff;
      cnt_in          = cnt_ff;
      hcnt_in         = hcnt_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;

      if (csr_valid) begin
         case (csr_index)
            harrs_pkg::CSR_NUM_ENDPOINTS: num_ep_in       = csr_wdata[3:0];
            harrs_pkg::CSR_PATH_COUNTS:   path_counts_in  = csr_wdata;
            harrs_pkg::CSR_FAIL_TIMEOUT:  fail_timeout_in = csr_wdata;
            harrs_pkg::CSR_HINT_ENABLE:   hint_en_in      = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (cmd.load_req) begin
         req_in = req_data;
         res_in = '{status: harrs_pkg::ST_OK, chosen_endpoint: 3'd0,
                    hint_valid: 1'b0, chosen_path: 3'd0};
      end

      if (cmd.set_status) begin
         res_in.status = cmd.status;
      end

      if (cmd.fail_mark) begin
         ep_failed_in[fe_e] = 1'b1;
         ep_time_in[fe_e]   = now_t;
         cur_ep_in          = fe_e;
         if (sts.fail_single) begin
            path_failed_in[fe_e][fp_p] = 1'b1;
            idx_in                     = fp_p;
         end else begin
            path_failed_in[fe_e] = path_failed_ff[fe_e] | path_mask(c_fe);
            idx_in               = '0;
         end
      end

      if (cmd.fail_write || cmd.path_next) begin
         idx_in = idx_inc;
      end

      if (cmd.ep_start) begin
         cnt_in = '0;
      end

      if (cmd.ep_step) begin
         ep_ptr_in = nx;
         cur_ep_in = nx;
         cnt_in    = NW'(32'(cnt_ff) + 32'd1);
         idx_in    = '0;
      end

      if (cmd.pick_chosen) begin
         res_in.chosen_endpoint = 3'(cur_ep_ff);
         hcnt_in                = '0;
      end

      if (cmd.hint_probe) begin
         path_ptr_in[cur_ep_ff] = hnext;
         idx_in                 = hidx;
         hcnt_in                = CW'(32'(hcnt_ff) + 32'd1);
         if (!hfail) begin
            res_in.hint_valid  = 1'b1;
            res_in.chosen_path = 3'(hidx);
         end
      end

      if (cmd.hint_clear) begin
         path_failed_in[cur_ep_ff][idx_ff] = 1'b0;
         res_in.hint_valid                 = 1'b1;
         res_in.chosen_path                = 3'(idx_ff);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ep_ff       <= '0;
         path_counts_ff  <= '0;
         fail_timeout_ff <= harrs_pkg::FAIL_TIMEOUT_RESET;
         hint_en_ff      <= 1'b0;
         ep_ptr_ff       <= '0;
         ep_failed_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int e = 0; e < MAX_ENDPOINTS; e++) begin
            path_ptr_ff[e]    <= '0;
            path_failed_ff[e] <= '0;
         end
      end else begin
         num_ep_ff       <= num_ep_in;
         path_counts_ff  <= path_counts_in;
         fail_timeout_ff <= fail_timeout_in;
         hint_en_ff      <= hint_en_in;
         ep_ptr_ff       <= ep_ptr_in;
         ep_failed_ff    <= ep_failed_in;
         rsp_valid_ff    <= rsp_valid_in;
         path_ptr_ff     <= path_ptr_in;
         path_failed_ff  <= path_failed_in;
      end
   end

   // stamps are read only behind a set failure mark
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cur_ep_ff  <= cur_ep_in;
      ep_time_ff <= ep_time_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      hcnt_ff    <= hcnt_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hint_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hint_valid |-> rsp_ff.status == harrs_pkg::ST_OK)
      else $error("sub-path hint given with a failing status");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != harrs_pkg::ST_OK |->
         rsp_ff.chosen_endpoint == 3'd0 && !rsp_ff.hint_valid && rsp_ff.chosen_path == 3'd0)
      else $error("error response carries selection fields");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending transaction overwritten in output register");

   a_clear_marked: assert property (@(posedge clock) disable iff (reset)
      cmd.hint_clear |-> path_failed_ff[cur_ep_ff][idx_ff])
      else $error("expiry cleared a sub-path that was not marked failed");

endmodule

// ===== rtl/health_aware_round_robin_selector.sv =====
// Two-level round-robin path selector with expiring failure marks. One request
// is worked at a time; a finished response waits in an output register, so the
// next request is taken while it is still pending. A pick steps through the
// endpoints in turn, reads the sub-path stamps of an endpoint whose every
// sub-path is marked failed, and then tries sub-paths for the hint, aging the
// mark of the last one tried when it is marked failed. A failure report stamps
// each sub-path that it marks. A response held by the receiver stalls the next
// finished pick. The sub-path timestamps sit in a RAM with one write port and
// one registered read port, one stamp per cycle.
// Configuration writes are always taken and must be made only while the block
// is idle.
module health_aware_round_robin_selector #(
   parameter int MAX_ENDPOINTS = 8,
   parameter int MAX_PATHS     = 8,
   parameter int TIME_BITS     = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  harrs_pkg::req_type       req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output harrs_pkg::rsp_type       rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  harrs_pkg::csr_index_type csr_index,
   input  logic [31:0]              csr_wdata
);

   harrs_pkg::cmd_type cmd;
   harrs_pkg::sts_type sts;

   harrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   harrs_dpath #(
      .MAX_ENDPOINTS (MAX_ENDPOINTS),
      .MAX_PATHS     (MAX_PATHS),
      .TIME_BITS     (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
